// File: rtl/core/roc_pkg.sv
// Package for the ROC / precision-recall curve accumulator.
// It holds the item structs, the action, status and class codes, and the sequencer states.
// It depends on nothing. The top level uses it.
package roc_pkg;

    localparam int NODE_W  = 16;
    localparam int RATE_W  = 17;
    localparam int AREA_W  = 34;
    localparam int COUNT_W = 32;
    localparam logic [RATE_W-1:0] RATE_ONE = 17'd65536;
    localparam logic [AREA_W-1:0] AREA_MAX = 34'h2_0000_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [2:0] ACT_CLEAR    = 3'd0;
    localparam logic [2:0] ACT_LOAD_TRUE = 3'd1;
    localparam logic [2:0] ACT_LOAD_NEG = 3'd2;
    localparam logic [2:0] ACT_RESTART  = 3'd3;
    localparam logic [2:0] ACT_SCORE    = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_ORDER = 2'd2;

    localparam logic [1:0] CLS_NONE = 2'd0;
    localparam logic [1:0] CLS_TP   = 2'd1;
    localparam logic [1:0] CLS_FP   = 2'd2;

    localparam logic [0:0] REG_TOTAL_TRUE  = 1'd0;
    localparam logic [0:0] REG_TOTAL_FALSE = 1'd1;

    typedef struct packed {
        logic [2:0]        action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [1:0]         edge_class;
        logic [COUNT_W-1:0] tp_count;
        logic [COUNT_W-1:0] fp_count;
        logic [COUNT_W-1:0] edge_count;
        logic [RATE_W-1:0]  true_rate;
        logic [RATE_W-1:0]  false_rate;
        logic [RATE_W-1:0]  precision;
        logic [AREA_W-1:0]  roc_area;
        logic [AREA_W-1:0]  pr_area;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_UPD,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_AREA_MUL,
        ST_AREA_ADD,
        ST_COMMIT,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/core/roc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// It depends on nothing.
module roc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/roc_auc_accumulator.sv
// ROC / precision-recall curve accumulator: top level. Uses roc_pkg and roc_ram.
// Clear, load, restart and unused actions go straight to output. A scored edge searches the true
// table, then the negative table if not found (a probe state reads, the compare state compares),
// then updates, divides for the true rate, false rate and precision (skipped for a zero or
// saturated rate), adds both areas once more than one edge is counted, commits and outputs.
// One item at a time, taken only in idle. Reset clears control and counters, not the RAMs.
module roc_auc_accumulator #(
    parameter int NODE_BITS   = 16,
    parameter int TABLE_DEPTH = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  roc_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_stall,
    output roc_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int KEY_W  = 2 * NODE_BITS;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [FILL_W-1:0] DEPTH_FILL = FILL_W'(TABLE_DEPTH);

    // Sequencer and datapath registers.
    roc_pkg::state_t state_reg, state_next;
    logic [FILL_W-1:0]  true_fill_reg, true_fill_next;
    logic [FILL_W-1:0]  neg_fill_reg, neg_fill_next;
    logic [KEY_W-1:0]   last_true_key_reg, last_true_key_next;
    logic [KEY_W-1:0]   last_neg_key_reg, last_neg_key_next;
    logic [31:0]        total_true_reg, total_true_next;
    logic [31:0]        total_false_reg, total_false_next;
    logic [31:0]        tp_reg, tp_next;
    logic [31:0]        fp_reg, fp_next;
    logic [31:0]        edges_reg, edges_next;
    logic [16:0]        last_tpr_reg, last_tpr_next;
    logic [16:0]        last_fpr_reg, last_fpr_next;
    logic [16:0]        last_ppv_reg, last_ppv_next;
    logic [16:0]        new_tpr_reg, new_tpr_next;
    logic [16:0]        new_fpr_reg, new_fpr_next;
    logic [16:0]        new_ppv_reg, new_ppv_next;
    logic [33:0]        auc_reg, auc_next;
    logic [33:0]        aupr_reg, aupr_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [1:0]         status_reg, status_next;
    logic [1:0]         cls_reg, cls_next;
    logic               tbl_sel_reg, tbl_sel_next;
    logic [FILL_W-1:0]  lo_reg, lo_next;
    logic [FILL_W-1:0]  hi_reg, hi_next;
    logic [FILL_W-1:0]  mid_reg, mid_next;
    logic [1:0]         div_idx_reg, div_idx_next;
    logic [4:0]         div_cnt_reg, div_cnt_next;
    logic [31:0]        rem_reg, rem_next;
    logic [15:0]        quo_reg, quo_next;
    logic               area_idx_reg, area_idx_next;
    logic signed [36:0] prod_reg, prod_next;
    logic               out_valid_reg, out_valid_next;
    roc_pkg::out_item_t out_item_reg, out_item_next;

    // Key formation: both nodes are taken modulo 2^NODE_BITS and ordered larger first.
    logic [NODE_BITS-1:0] na, nb;
    logic [KEY_W-1:0]     key_in;
    logic                 in_acc;

    assign na     = NODE_BITS'(in_item.node_a);
    assign nb     = NODE_BITS'(in_item.node_b);
    assign key_in = (na < nb) ? {nb, na} : {na, nb};
    assign in_acc = in_valid && !in_stall;

    assign in_stall  = (state_reg != roc_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Table memories. Loads write on the accepting edge; searches read at the probe index.
    logic              true_we, neg_we;
    logic [KEY_W-1:0]  true_rdata, neg_rdata, rdata;
    logic [ADDR_W-1:0] raddr;

    roc_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_true_ram (
        .clk   (clk),
        .we    (true_we),
        .waddr (true_fill_reg[ADDR_W-1:0]),
        .wdata (key_in),
        .raddr (raddr),
        .rdata (true_rdata)
    );

    roc_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_neg_ram (
        .clk   (clk),
        .we    (neg_we),
        .waddr (neg_fill_reg[ADDR_W-1:0]),
        .wdata (key_in),
        .raddr (raddr),
        .rdata (neg_rdata)
    );

    assign rdata = tbl_sel_reg ? neg_rdata : true_rdata;

    // A load is dropped when the table is full or the key falls below the last loaded key.
    logic [1:0] true_load_stat, neg_load_stat;

    always_comb
    begin
        if (true_fill_reg >= DEPTH_FILL)
            true_load_stat = roc_pkg::STAT_FULL;
        else if (true_fill_reg != '0 && key_in < last_true_key_reg)
            true_load_stat = roc_pkg::STAT_ORDER;
        else
            true_load_stat = roc_pkg::STAT_OK;
        if (neg_fill_reg >= DEPTH_FILL)
            neg_load_stat = roc_pkg::STAT_FULL;
        else if (neg_fill_reg != '0 && key_in < last_neg_key_reg)
            neg_load_stat = roc_pkg::STAT_ORDER;
        else
            neg_load_stat = roc_pkg::STAT_OK;
    end

    assign true_we = in_acc && in_item.action == roc_pkg::ACT_LOAD_TRUE
                     && true_load_stat == roc_pkg::STAT_OK;
    assign neg_we  = in_acc && in_item.action == roc_pkg::ACT_LOAD_NEG
                     && neg_load_stat == roc_pkg::STAT_OK;

    // Binary search probe: the middle of the live window.
    logic [FILL_W-1:0] mid_calc;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign raddr    = mid_calc[ADDR_W-1:0];

    // Divider operand selection: true rate, false rate, then precision.
    logic [31:0] div_num, div_den;
    always_comb
    begin
        case (div_idx_reg)
            2'd0:
            begin
                div_num = tp_reg;
                div_den = total_true_reg;
            end
            2'd1:
            begin
                div_num = fp_reg;
                div_den = total_false_reg;
            end
            default:
            begin
                div_num = tp_reg;
                div_den = edges_reg;
            end
        endcase
    end

    // One restoring step per cycle; the remainder always stays below the divisor.
    logic [32:0] rem_dbl;
    logic        div_bit;
    logic [15:0] quo_step;
    assign rem_dbl  = {rem_reg, 1'b0};
    assign div_bit  = (rem_dbl >= {1'b0, div_den});
    assign quo_step = {quo_reg[14:0], div_bit};

    // Trapezoid operands: ROC first, then precision-recall.
    logic [16:0] y0, y1, x0, x1;
    logic signed [18:0] y_sum;
    logic signed [17:0] x_diff;
    logic [33:0] area_old;
    logic signed [37:0] area_sum;
    logic [33:0] area_clamp;

    assign y0 = area_idx_reg ? last_ppv_reg : last_tpr_reg;
    assign y1 = area_idx_reg ? new_ppv_reg : new_tpr_reg;
    assign x0 = area_idx_reg ? last_tpr_reg : last_fpr_reg;
    assign x1 = area_idx_reg ? new_tpr_reg : new_fpr_reg;
    assign y_sum  = $signed({2'b00, y0}) + $signed({2'b00, y1});
    assign x_diff = $signed({1'b0, x1}) - $signed({1'b0, x0});
    assign area_old = area_idx_reg ? aupr_reg : auc_reg;
    assign area_sum = $signed({4'b0000, area_old}) + 38'(prod_reg);

    always_comb
    begin
        if (area_sum < 0)
            area_clamp = '0;
        else if (area_sum > $signed({4'b0000, roc_pkg::AREA_MAX}))
            area_clamp = roc_pkg::AREA_MAX;
        else
            area_clamp = area_sum[33:0];
    end

    // Next-state and datapath update.
    always_comb
    begin
        state_next         = state_reg;
        true_fill_next     = true_fill_reg;
        neg_fill_next      = neg_fill_reg;
        last_true_key_next = last_true_key_reg;
        last_neg_key_next  = last_neg_key_reg;
        total_true_next    = total_true_reg;
        total_false_next   = total_false_reg;
        tp_next            = tp_reg;
        fp_next            = fp_reg;
        edges_next         = edges_reg;
        last_tpr_next      = last_tpr_reg;
        last_fpr_next      = last_fpr_reg;
        last_ppv_next      = last_ppv_reg;
        new_tpr_next       = new_tpr_reg;
        new_fpr_next       = new_fpr_reg;
        new_ppv_next       = new_ppv_reg;
        auc_next           = auc_reg;
        aupr_next          = aupr_reg;
        key_next           = key_reg;
        status_next        = status_reg;
        cls_next           = cls_reg;
        tbl_sel_next       = tbl_sel_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        mid_next           = mid_reg;
        div_idx_next       = div_idx_reg;
        div_cnt_next       = div_cnt_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        area_idx_next      = area_idx_reg;
        prod_next          = prod_reg;
        out_item_next      = out_item_reg;
        out_valid_next     = out_valid_reg && out_stall;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                roc_pkg::REG_TOTAL_TRUE:  total_true_next  = cfg_data;
                roc_pkg::REG_TOTAL_FALSE: total_false_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            roc_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    key_next    = key_in;
                    status_next = roc_pkg::STAT_OK;
                    cls_next    = roc_pkg::CLS_NONE;
                    state_next  = roc_pkg::ST_FINISH;
                    case (in_item.action)
                        roc_pkg::ACT_CLEAR:
                        begin
                            true_fill_next = '0;
                            neg_fill_next  = '0;
                        end
                        roc_pkg::ACT_LOAD_TRUE:
                        begin
                            status_next = true_load_stat;
                            if (true_we)
                            begin
                                true_fill_next     = true_fill_reg + 1'b1;
                                last_true_key_next = key_in;
                            end
                        end
                        roc_pkg::ACT_LOAD_NEG:
                        begin
                            status_next = neg_load_stat;
                            if (neg_we)
                            begin
                                neg_fill_next     = neg_fill_reg + 1'b1;
                                last_neg_key_next = key_in;
                            end
                        end
                        roc_pkg::ACT_RESTART:
                        begin
                            tp_next       = '0;
                            fp_next       = '0;
                            edges_next    = '0;
                            last_tpr_next = '0;
                            last_fpr_next = '0;
                            last_ppv_next = '0;
                            auc_next      = '0;
                            aupr_next     = '0;
                        end
                        roc_pkg::ACT_SCORE:
                        begin
                            tbl_sel_next = 1'b0;
                            lo_next      = '0;
                            hi_next      = true_fill_reg;
                            state_next   = roc_pkg::ST_SRCH;
                        end
                        default: ;
                    endcase
                end
            end

            roc_pkg::ST_SRCH:
            begin
                // The RAM read at the probe index is issued on this edge.
                mid_next = mid_calc;
                if (lo_reg < hi_reg)
                begin
                    state_next = roc_pkg::ST_CMP;
                end
                else if (!tbl_sel_reg && neg_fill_reg != '0)
                begin
                    tbl_sel_next = 1'b1;
                    lo_next      = '0;
                    hi_next      = neg_fill_reg;
                end
                else
                begin
                    cls_next   = tbl_sel_reg ? roc_pkg::CLS_NONE : roc_pkg::CLS_FP;
                    state_next = roc_pkg::ST_UPD;
                end
            end

            roc_pkg::ST_CMP:
            begin
                if (rdata == key_reg)
                begin
                    cls_next   = tbl_sel_reg ? roc_pkg::CLS_FP : roc_pkg::CLS_TP;
                    state_next = roc_pkg::ST_UPD;
                end
                else
                begin
                    if (rdata < key_reg)
                        lo_next = mid_reg + 1'b1;
                    else
                        hi_next = mid_reg;
                    state_next = roc_pkg::ST_SRCH;
                end
            end

            roc_pkg::ST_UPD:
            begin
                if (cls_reg == roc_pkg::CLS_TP && tp_reg != roc_pkg::COUNT_MAX)
                    tp_next = tp_reg + 1'b1;
                if (cls_reg == roc_pkg::CLS_FP && fp_reg != roc_pkg::COUNT_MAX)
                    fp_next = fp_reg + 1'b1;
                if (edges_reg != roc_pkg::COUNT_MAX)
                    edges_next = edges_reg + 1'b1;
                div_idx_next = 2'd0;
                state_next   = roc_pkg::ST_DIV_INIT;
            end

            roc_pkg::ST_DIV_INIT:
            begin
                // A zero total gives 0; a numerator at or above the total saturates at 1.0.
                rem_next     = div_num;
                quo_next     = '0;
                div_cnt_next = 5'd16;
                if (div_den == '0 || div_num >= div_den)
                begin
                    case (div_idx_reg)
                        2'd0:    new_tpr_next = (div_den == '0) ? '0 : roc_pkg::RATE_ONE;
                        2'd1:    new_fpr_next = (div_den == '0) ? '0 : roc_pkg::RATE_ONE;
                        default: new_ppv_next = (div_den == '0) ? '0 : roc_pkg::RATE_ONE;
                    endcase
                    if (div_idx_reg == 2'd2)
                    begin
                        area_idx_next = 1'b0;
                        state_next    = (edges_reg > 32'd1) ? roc_pkg::ST_AREA_MUL
                                                            : roc_pkg::ST_COMMIT;
                    end
                    else
                    begin
                        div_idx_next = div_idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = roc_pkg::ST_DIV_RUN;
                end
            end

            roc_pkg::ST_DIV_RUN:
            begin
                rem_next     = div_bit ? 32'(rem_dbl - {1'b0, div_den}) : rem_dbl[31:0];
                quo_next     = quo_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == 5'd1)
                begin
                    case (div_idx_reg)
                        2'd0:    new_tpr_next = {1'b0, quo_step};
                        2'd1:    new_fpr_next = {1'b0, quo_step};
                        default: new_ppv_next = {1'b0, quo_step};
                    endcase
                    if (div_idx_reg == 2'd2)
                    begin
                        area_idx_next = 1'b0;
                        state_next    = (edges_reg > 32'd1) ? roc_pkg::ST_AREA_MUL
                                                            : roc_pkg::ST_COMMIT;
                    end
                    else
                    begin
                        div_idx_next = div_idx_reg + 1'b1;
                        state_next   = roc_pkg::ST_DIV_INIT;
                    end
                end
            end

            roc_pkg::ST_AREA_MUL:
            begin
                prod_next  = 37'(y_sum) * 37'(x_diff);
                state_next = roc_pkg::ST_AREA_ADD;
            end

            roc_pkg::ST_AREA_ADD:
            begin
                if (area_idx_reg)
                begin
                    aupr_next  = area_clamp;
                    state_next = roc_pkg::ST_COMMIT;
                end
                else
                begin
                    auc_next      = area_clamp;
                    area_idx_next = 1'b1;
                    state_next    = roc_pkg::ST_AREA_MUL;
                end
            end

            roc_pkg::ST_COMMIT:
            begin
                last_tpr_next = new_tpr_reg;
                last_fpr_next = new_fpr_reg;
                last_ppv_next = new_ppv_reg;
                state_next    = roc_pkg::ST_FINISH;
            end

            roc_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next           = 1'b1;
                    out_item_next.status     = status_reg;
                    out_item_next.edge_class = cls_reg;
                    out_item_next.tp_count   = tp_reg;
                    out_item_next.fp_count   = fp_reg;
                    out_item_next.edge_count = edges_reg;
                    out_item_next.true_rate  = last_tpr_reg;
                    out_item_next.false_rate = last_fpr_reg;
                    out_item_next.precision  = last_ppv_reg;
                    out_item_next.roc_area   = auc_reg;
                    out_item_next.pr_area    = aupr_reg;
                    state_next               = roc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = roc_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state resets; payload and search scratch registers do not need to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= roc_pkg::ST_IDLE;
            true_fill_reg   <= '0;
            neg_fill_reg    <= '0;
            total_true_reg  <= '0;
            total_false_reg <= '0;
            tp_reg          <= '0;
            fp_reg          <= '0;
            edges_reg       <= '0;
            last_tpr_reg    <= '0;
            last_fpr_reg    <= '0;
            last_ppv_reg    <= '0;
            auc_reg         <= '0;
            aupr_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            true_fill_reg   <= true_fill_next;
            neg_fill_reg    <= neg_fill_next;
            total_true_reg  <= total_true_next;
            total_false_reg <= total_false_next;
            tp_reg          <= tp_next;
            fp_reg          <= fp_next;
            edges_reg       <= edges_next;
            last_tpr_reg    <= last_tpr_next;
            last_fpr_reg    <= last_fpr_next;
            last_ppv_reg    <= last_ppv_next;
            auc_reg         <= auc_next;
            aupr_reg        <= aupr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_true_key_reg <= last_true_key_next;
        last_neg_key_reg  <= last_neg_key_next;
        new_tpr_reg       <= new_tpr_next;
        new_fpr_reg       <= new_fpr_next;
        new_ppv_reg       <= new_ppv_next;
        key_reg           <= key_next;
        status_reg        <= status_next;
        cls_reg           <= cls_next;
        tbl_sel_reg       <= tbl_sel_next;
        lo_reg            <= lo_next;
        hi_reg            <= hi_next;
        mid_reg           <= mid_next;
        div_idx_reg       <= div_idx_next;
        div_cnt_reg       <= div_cnt_next;
        rem_reg           <= rem_next;
        quo_reg           <= quo_next;
        area_idx_reg      <= area_idx_next;
        prod_reg          <= prod_next;
        out_item_reg      <= out_item_next;
    end

    // A table is never written past its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (true_we || neg_we) |-> (true_we ? true_fill_reg < DEPTH_FILL
                                         : neg_fill_reg < DEPTH_FILL))
        else $error("table write beyond depth");

    // Stored rates never exceed 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_tpr_reg <= roc_pkg::RATE_ONE) && (last_fpr_reg <= roc_pkg::RATE_ONE)
        && (last_ppv_reg <= roc_pkg::RATE_ONE))
        else $error("rate above one");

    // Both areas stay within their clamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        (auc_reg <= roc_pkg::AREA_MAX) && (aupr_reg <= roc_pkg::AREA_MAX))
        else $error("area above clamp");

    // A score item always leaves the idle state for the search.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && in_item.action == roc_pkg::ACT_SCORE) |=> (state_reg == roc_pkg::ST_SRCH))
        else $error("score item did not start a search");

endmodule
